// ----- rtl/ppde_pkg.sv -----
`default_nettype none

package ppde_pkg;

   // table geometry
   localparam int TABLE_ENTRIES = 16;
   localparam int DURATION_BITS = 16;
   localparam int TOL_BITS      = 16;
   localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
   localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);

   localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(100);

   // one stored pulse pair
   typedef struct packed {
      logic [DURATION_BITS-1:0] mark;
      logic [DURATION_BITS-1:0] space;
   } ppde_entry_type;

   // table write request
   typedef struct packed {
      logic                en;
      logic [IDX_BITS-1:0] addr;
      ppde_entry_type      data;
   } ppde_wr_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_RESP = 3'b100
   } ppde_state_type;

endpackage

`default_nettype wire

// ----- rtl/ppde_req_if.sv -----
`default_nettype none

interface ppde_req_if;
   logic                               valid;
   logic                               ready;
   logic [ppde_pkg::DURATION_BITS-1:0] mark_time;
   logic [ppde_pkg::DURATION_BITS-1:0] space_time;
   logic                               frame_start;

   modport source (output valid, output mark_time, output space_time, output frame_start,
                   input ready);
   modport sink (input valid, input mark_time, input space_time, input frame_start,
                 output ready);
endinterface

`default_nettype wire

// ----- rtl/ppde_rsp_if.sv -----
`default_nettype none

interface ppde_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ppde_pkg::IDX_BITS-1:0] entry_index;
   logic                          new_entry;
   logic                          table_overflow;
   logic [ppde_pkg::CNT_BITS-1:0] entries_used;

   modport source (output valid, output entry_index, output new_entry,
                   output table_overflow, output entries_used, input ready);
   modport sink (input valid, input entry_index, input new_entry,
                 input table_overflow, input entries_used, output ready);
endinterface

`default_nettype wire

// ----- rtl/ppde_table.sv -----
`default_nettype none

module ppde_table (
   input  logic                          clock,
   input  ppde_pkg::ppde_wr_type         wr,
   input  logic                          rd_en,
   input  logic [ppde_pkg::IDX_BITS-1:0] rd_addr,
   output ppde_pkg::ppde_entry_type      rd_data
);
   import ppde_pkg::*;

   ppde_entry_type mem [TABLE_ENTRIES];
   ppde_entry_type rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/ppde_match_unit.sv -----
`default_nettype none

module ppde_match_unit (
   input  ppde_pkg::ppde_entry_type             entry,
   input  logic [ppde_pkg::DURATION_BITS-1:0]   mark,
   input  logic [ppde_pkg::DURATION_BITS-1:0]   space,
   input  logic [ppde_pkg::TOL_BITS-1:0]        tol,
   output logic                                 hit
);
   import ppde_pkg::*;

   logic [DURATION_BITS-1:0] mark_diff;
   logic [DURATION_BITS-1:0] space_diff;

   // absolute differences, no wrap
   always_comb begin
      mark_diff  = (mark >= entry.mark) ? (mark - entry.mark) : (entry.mark - mark);
      space_diff = (space >= entry.space) ? (space - entry.space) : (entry.space - space);
      hit = (mark_diff < tol) && (space_diff < tol);
   end

endmodule

`default_nettype wire

// ----- rtl/pulse_pair_dictionary_encoder_unit.sv -----
`default_nettype none

// pulse pair dictionary encoder
// req_ch takes one item per pulse pair: mark_time, space_time and frame_start.
// rsp_ch returns one item per pair: entry_index, new_entry, table_overflow and
// entries_used, the last two as they stand after the pair.
// csr_wr_en / csr_wr_data write the match tolerance (reset value 100); write
// only while the block is idle.
// an item is accepted when valid and ready are both high. ready is high only
// in the idle state; each pair is scanned against the stored entries one entry
// per cycle through a single shared compare unit fed by a registered table read.
// the scan stops early on a match, and the next item is not accepted until the
// result has been loaded into the output register and the block is idle again.
// the result sits in an output register; if the receiver stalls, the block
// still takes and scans the next pair and waits in the response state until
// the register frees up.
// synchronous reset empties the table, clears overflow, drops rsp valid and
// restores the tolerance; table contents are left as they were.
module pulse_pair_dictionary_encoder_unit (
   input  logic                          clock,
   input  logic                          reset,
   ppde_req_if.sink                      req_ch,
   ppde_rsp_if.source                    rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [ppde_pkg::TOL_BITS-1:0] csr_wr_data
);
   import ppde_pkg::*;

   ppde_state_type state_ff, state_in;

   logic [TOL_BITS-1:0]      tol_ff, tol_in;
   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic                     ovf_ff, ovf_in;

   // latched pair under scan
   logic [DURATION_BITS-1:0] mark_ff, mark_in;
   logic [DURATION_BITS-1:0] space_ff, space_in;

   // scan pointers: issue side and compare side
   logic [CNT_BITS-1:0]      scan_ptr_ff, scan_ptr_in;
   logic                     cmp_vld_ff, cmp_vld_in;
   logic [IDX_BITS-1:0]      cmp_ptr_ff, cmp_ptr_in;

   // result of the finished scan
   logic [IDX_BITS-1:0]      res_idx_ff, res_idx_in;
   logic                     res_new_ff, res_new_in;

   // output register
   logic                     rsp_vld_ff, rsp_vld_in;
   logic [IDX_BITS-1:0]      rsp_idx_ff, rsp_idx_in;
   logic                     rsp_new_ff, rsp_new_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;
   logic [CNT_BITS-1:0]      rsp_used_ff, rsp_used_in;

   ppde_wr_type              tbl_wr;
   logic                     tbl_rd_en;
   ppde_entry_type           tbl_rd_data;
   logic                     hit;
   logic                     req_accept;
   logic                     rsp_load;

   ppde_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_en   (tbl_rd_en),
      .rd_addr (scan_ptr_ff[IDX_BITS-1:0]),
      .rd_data (tbl_rd_data)
   );

   // shared compare unit, one entry per cycle
   ppde_match_unit u_match (
      .entry (tbl_rd_data),
      .mark  (mark_ff),
      .space (space_ff),
      .tol   (tol_ff),
      .hit   (hit)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && (state_ff == ST_IDLE);
   assign rsp_load     = (state_ff == ST_RESP) && (!rsp_vld_ff || rsp_ch.ready);

   always_comb begin
      state_in    = state_ff;
      tol_in      = csr_wr_en ? csr_wr_data : tol_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      mark_in     = mark_ff;
      space_in    = space_ff;
      scan_ptr_in = scan_ptr_ff;
      cmp_vld_in  = cmp_vld_ff;
      cmp_ptr_in  = cmp_ptr_ff;
      res_idx_in  = res_idx_ff;
      res_new_in  = res_new_ff;
      tbl_rd_en   = 1'b0;
      tbl_wr.en   = 1'b0;
      tbl_wr.addr = count_ff[IDX_BITS-1:0];
      tbl_wr.data = '{mark: mark_ff, space: space_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               mark_in     = req_ch.mark_time;
               space_in    = req_ch.space_time;
               // frame start empties the table before this pair
               if (req_ch.frame_start) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
               end
               scan_ptr_in = '0;
               cmp_vld_in  = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cmp_vld_ff && hit) begin
               // first matching entry wins
               res_idx_in = cmp_ptr_ff;
               res_new_in = 1'b0;
               state_in   = ST_RESP;
            end else if (scan_ptr_ff == count_ff) begin
               // every valid entry checked, none matched
               if (count_ff < CNT_BITS'(TABLE_ENTRIES)) begin
                  tbl_wr.en  = 1'b1;
                  res_idx_in = count_ff[IDX_BITS-1:0];
                  res_new_in = 1'b1;
                  count_in   = count_ff + CNT_BITS'(1);
               end else begin
                  // table full: nothing stored, sticky overflow
                  res_idx_in = '0;
                  res_new_in = 1'b0;
                  ovf_in     = 1'b1;
               end
               state_in = ST_RESP;
            end else begin
               tbl_rd_en   = 1'b1;
               cmp_vld_in  = 1'b1;
               cmp_ptr_in  = scan_ptr_ff[IDX_BITS-1:0];
               scan_ptr_in = scan_ptr_ff + CNT_BITS'(1);
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register, loaded once the previous item has left
   always_comb begin
      rsp_idx_in  = rsp_idx_ff;
      rsp_new_in  = rsp_new_ff;
      rsp_ovf_in  = rsp_ovf_ff;
      rsp_used_in = rsp_used_ff;
      if (rsp_load) begin
         rsp_vld_in  = 1'b1;
         rsp_idx_in  = res_idx_ff;
         rsp_new_in  = res_new_ff;
         rsp_ovf_in  = ovf_ff;
         rsp_used_in = count_ff;
      end else if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         tol_ff     <= TOL_RESET;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         tol_ff     <= tol_in;
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      mark_ff     <= mark_in;
      space_ff    <= space_in;
      scan_ptr_ff <= scan_ptr_in;
      cmp_ptr_ff  <= cmp_ptr_in;
      res_idx_ff  <= res_idx_in;
      res_new_ff  <= res_new_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_new_ff  <= rsp_new_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_used_ff <= rsp_used_in;
   end

   assign rsp_ch.valid          = rsp_vld_ff;
   assign rsp_ch.entry_index    = rsp_idx_ff;
   assign rsp_ch.new_entry      = rsp_new_ff;
   assign rsp_ch.table_overflow = rsp_ovf_ff;
   assign rsp_ch.entries_used   = rsp_used_ff;

`ifndef SYNTHESIS
   // a new entry is always the last one in the table
   a_new_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_new_ff) |->
         (rsp_used_ff == CNT_BITS'(rsp_idx_ff) + CNT_BITS'(1)))
      else $error("new entry index does not match entry count");

   // overflow only with a full table
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (count_ff == CNT_BITS'(TABLE_ENTRIES)))
      else $error("overflow flag set with table not full");

   // scan never issues past the valid entries
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_ptr_ff <= count_ff))
      else $error("scan pointer beyond entry count");

   // an accepted item starts a scan
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_SCAN))
      else $error("accepted item did not start a scan");
`endif

endmodule

`default_nettype wire
